// ----- rtl/lecb_pkg.sv -----
// ============================================================================
// lecb_pkg
// Shared types and constants for the link event coalescing buffer.
// ============================================================================
package lecb_pkg;

    localparam int unsigned BUFFER_DEPTH_DEFAULT = 16;
    localparam logic [31:0] TIMEOUT_RESET        = 32'd500;
    localparam int unsigned DATA_W               = 160;
    localparam int unsigned FUNC_W               = 2;

    // Stored entry; packs with insert in bit 0, name_high on top.
    typedef struct packed {
        logic [63:0] name_high;
        logic [63:0] name_low;
        logic [30:0] index;
        logic        insert;
    } entry_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_EVENT = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_FLUSH = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FLUSH_OUT,
        ST_SEARCH,
        ST_CMP
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load_in;    // latch the accepted item
        logic ptr_clr;    // pointer to oldest entry
        logic ptr_inc;
        logic ptr_dec;
        logic ptr_top;    // pointer to newest entry
        logic rd_en;      // read store at next pointer value
        logic wr_en;      // write latched event
        logic wr_at_ptr;  // overwrite at pointer, else append
        logic out_load;   // load read entry into output register
        logic fill_clr;
        logic tmr_stop;
        logic tmr_dec;
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        func_t func;
        logic  fill_zero;
        logic  fill_full;
        logic  ptr_zero;
        logic  ptr_last;
        logic  idx_match;
        logic  rd_insert;
        logic  in_insert;
        logic  running;
        logic  expire;
        logic  out_free;
    } status_t;

endpackage

// ----- rtl/lecb_ctrl.sv -----
// ============================================================================
// lecb_ctrl
// Sequencer: decodes each item, runs flushes and the backward search.
// ============================================================================
module lecb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              in_ready,
    input  lecb_pkg::status_t status,
    output lecb_pkg::cmd_t    cmd
);

    lecb_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lecb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == lecb_pkg::ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            lecb_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = lecb_pkg::ST_DECODE;
                end
            end
            lecb_pkg::ST_DECODE: begin
                unique case (status.func)
                    lecb_pkg::FUNC_EVENT: begin
                        if (status.fill_full) begin
                            cmd.tmr_stop = 1'b1;
                            cmd.ptr_clr  = 1'b1;
                            cmd.rd_en    = 1'b1;
                            state_next   = lecb_pkg::ST_FLUSH_OUT;
                        end else begin
                            state_next = lecb_pkg::ST_SEARCH;
                        end
                    end
                    lecb_pkg::FUNC_TICK: begin
                        state_next = lecb_pkg::ST_IDLE;
                        if (status.running) begin
                            if (status.expire) begin
                                cmd.tmr_stop = 1'b1;
                                if (!status.fill_zero) begin
                                    cmd.ptr_clr = 1'b1;
                                    cmd.rd_en   = 1'b1;
                                    state_next  = lecb_pkg::ST_FLUSH_OUT;
                                end
                            end else begin
                                cmd.tmr_dec = 1'b1;
                            end
                        end
                    end
                    lecb_pkg::FUNC_FLUSH: begin
                        cmd.tmr_stop = 1'b1;
                        state_next   = lecb_pkg::ST_IDLE;
                        if (!status.fill_zero) begin
                            cmd.ptr_clr = 1'b1;
                            cmd.rd_en   = 1'b1;
                            state_next  = lecb_pkg::ST_FLUSH_OUT;
                        end
                    end
                    default: begin
                        state_next = lecb_pkg::ST_IDLE;
                    end
                endcase
            end
            lecb_pkg::ST_FLUSH_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (status.ptr_last) begin
                        cmd.fill_clr = 1'b1;
                        // a full-store flush ahead of an event resumes the event
                        state_next = (status.func == lecb_pkg::FUNC_EVENT)
                                     ? lecb_pkg::ST_SEARCH : lecb_pkg::ST_IDLE;
                    end else begin
                        cmd.ptr_inc = 1'b1;
                        cmd.rd_en   = 1'b1;
                    end
                end
            end
            lecb_pkg::ST_SEARCH: begin
                if (status.fill_zero) begin
                    cmd.wr_en  = 1'b1;
                    state_next = lecb_pkg::ST_IDLE;
                end else begin
                    cmd.ptr_top = 1'b1;
                    cmd.rd_en   = 1'b1;
                    state_next  = lecb_pkg::ST_CMP;
                end
            end
            lecb_pkg::ST_CMP: begin
                if (status.idx_match) begin
                    cmd.wr_en     = 1'b1;
                    // removal followed by insertion keeps both
                    cmd.wr_at_ptr = !status.in_insert || status.rd_insert;
                    state_next    = lecb_pkg::ST_IDLE;
                end else if (status.ptr_zero) begin
                    cmd.wr_en  = 1'b1;
                    state_next = lecb_pkg::ST_IDLE;
                end else begin
                    cmd.ptr_dec = 1'b1;
                    cmd.rd_en   = 1'b1;
                end
            end
            default: begin
                state_next = lecb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/lecb_dp.sv -----
// ============================================================================
// lecb_dp
// Datapath: entry store, fill count, pointer, countdown and output register.
// ============================================================================
module lecb_dp #(
    parameter int unsigned BUFFER_DEPTH = lecb_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lecb_pkg::cmd_t              cmd,
    output lecb_pkg::status_t           status,
    input  logic [lecb_pkg::DATA_W-1:0] s_tdata,
    input  logic [lecb_pkg::FUNC_W-1:0] s_tuser,
    input  logic                        cfg_valid,
    input  logic [31:0]                 cfg_data,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lecb_pkg::DATA_W-1:0] m_tdata,
    output logic                        m_tlast
);

    localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);

    lecb_pkg::entry_t mem [BUFFER_DEPTH];
    lecb_pkg::entry_t rd_data_reg;
    lecb_pkg::entry_t in_reg;
    lecb_pkg::func_t  func_reg;

    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] wr_addr;
    logic [31:0]   timeout_reg;
    logic [31:0]   ticks_reg, ticks_next;
    logic          running_reg, running_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic          m_tlast_reg;
    lecb_pkg::entry_t m_data_reg;
    logic          ptr_last;

    // item latch
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg   <= lecb_pkg::entry_t'(s_tdata);
            func_reg <= lecb_pkg::func_t'(s_tuser);
        end
    end

    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.ptr_clr) begin
            ptr_next = '0;
        end else if (cmd.ptr_top) begin
            ptr_next = AW'(fill_reg - 1'b1);
        end else if (cmd.ptr_inc) begin
            ptr_next = ptr_reg + 1'b1;
        end else if (cmd.ptr_dec) begin
            ptr_next = ptr_reg - 1'b1;
        end
    end

    assign wr_addr = cmd.wr_at_ptr ? ptr_reg : AW'(fill_reg);

    // entry store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= in_reg;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[ptr_next];
        end
    end

    assign ptr_last = (CW'(ptr_reg) == CW'(fill_reg - 1'b1));

    always_comb begin
        fill_next = fill_reg;
        if (cmd.fill_clr) begin
            fill_next = '0;
        end else if (cmd.wr_en && !cmd.wr_at_ptr) begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_comb begin
        ticks_next   = ticks_reg;
        running_next = running_reg;
        if (cmd.wr_en) begin
            ticks_next   = timeout_reg;
            running_next = 1'b1;
        end else if (cmd.tmr_stop) begin
            ticks_next   = '0;
            running_next = 1'b0;
        end else if (cmd.tmr_dec) begin
            ticks_next = ticks_reg - 1'b1;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            ptr_reg      <= '0;
            ticks_reg    <= '0;
            running_reg  <= 1'b0;
            timeout_reg  <= lecb_pkg::TIMEOUT_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            fill_reg     <= fill_next;
            ptr_reg      <= ptr_next;
            ticks_reg    <= ticks_next;
            running_reg  <= running_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid) begin
                timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg  <= rd_data_reg;
            m_tlast_reg <= ptr_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_tlast_reg;

    assign status.func      = func_reg;
    assign status.fill_zero = (fill_reg == '0);
    assign status.fill_full = (fill_reg == CW'(BUFFER_DEPTH));
    assign status.ptr_zero  = (ptr_reg == '0);
    assign status.ptr_last  = ptr_last;
    assign status.idx_match = (rd_data_reg.index == in_reg.index);
    assign status.rd_insert = rd_data_reg.insert;
    assign status.in_insert = in_reg.insert;
    assign status.running   = running_reg;
    assign status.expire    = (ticks_reg[31:1] == '0);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(BUFFER_DEPTH))
        else $error("fill count above depth");

    a_append_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_en && !cmd.wr_at_ptr) |-> (fill_reg < CW'(BUFFER_DEPTH)))
        else $error("append into full store");

    a_write_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |=> (running_reg && ticks_reg == $past(timeout_reg)))
        else $error("countdown not restarted by event");

    a_flush_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && ptr_last) |=> (fill_reg == '0 && m_tlast_reg))
        else $error("flush end did not empty store");

endmodule

// ----- rtl/link_event_coalescing_buffer.sv -----
// ============================================================================
// link_event_coalescing_buffer
// Collects interface add/remove events, merges those for the same interface,
// and emits the stored run on a full store, an explicit flush or a timeout.
// ============================================================================
// A link event is appended directly to an empty store; else stored entries are
//   compared newest first (one read a cycle) until an index match or the oldest.
// A flush emits one item per cycle while m_tready stays high; a full store adds
//   the flush ahead of the event.
// Ticks and flushes of an empty store end in decode. One item in work at once.
// Reset (aresetn low, synchronous): store empty, countdown stopped, timeout 500.
module link_event_coalescing_buffer #(
    parameter int unsigned BUFFER_DEPTH = lecb_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input item channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [0] is_insert, [31:1] iface_index, [95:32] iface_name_low,
    // [159:96] iface_name_high
    input  logic [lecb_pkg::DATA_W-1:0] s_tdata,
    // [1:0] func
    input  logic [lecb_pkg::FUNC_W-1:0] s_tuser,
    // timeout register write
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [31:0]                 cfg_data,
    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [0] out_insert, [31:1] out_index, [95:32] out_name_low,
    // [159:96] out_name_high
    output logic [lecb_pkg::DATA_W-1:0] m_tdata,
    // last_of_flush
    output logic                        m_tlast
);

    lecb_pkg::cmd_t    cmd;
    lecb_pkg::status_t status;

    // Register is always writable; the host writes it only while idle (not enforced here).
    assign cfg_ready = 1'b1;

    // Sequencer: decode, flush walk, backward search.
    lecb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Entry store, counters, countdown and output register.
    lecb_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
